// ===== rtl/core/oss_pkg.sv =====
// Shared types and constants for the order statistic store.
// Holds the capacity, status and function codes, the cell control word and the FSM states.
// Depends on nothing.
package oss_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int RANK_W   = 16;
  localparam int COUNT_W  = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GROUP_N  = 8;
  localparam int GROUPS   = (CAPACITY + GROUP_N - 1) / GROUP_N;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_SELECT = 1'b1
  } func_t;

  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_COLLECT = 1'b1
  } state_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic ins;   // insert this cycle
    logic occ;   // cell holds a key
    logic tail;  // first free cell
    logic hit;   // cell is the selected rank
  } cell_ctrl_t;

endpackage

// ===== rtl/core/oss_cell.sv =====
// One cell of the sorted key chain: holds one key and shifts toward higher index on insert.
// Depends on oss_pkg.
module oss_cell (
  input  logic                                clk,
  input  oss_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [oss_pkg::KEY_W-1:0]    new_key,
  input  logic                                left_gt,
  input  logic signed [oss_pkg::KEY_W-1:0]    left_key,
  output logic                                gt,
  output logic signed [oss_pkg::KEY_W-1:0]    key,
  output logic        [oss_pkg::KEY_W-1:0]    sel_key
);
  import oss_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  assign gt      = ctrl.occ && (key_r > new_key);
  assign key     = key_r;
  assign sel_key = ctrl.hit ? key_r : '0;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        key_nxt = left_key;
      end else if (gt || ctrl.tail) begin
        key_nxt = new_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== rtl/core/order_statistic_store.sv =====
// Top level of the order statistic store: cell chain, rank gather tree, control, result register.
// Depends on oss_pkg and oss_cell.
//
//  channel | direction | word                               | handshake
//  in      | input     | func, new_key, rank                | in_valid / in_ready
//  out     | output    | status, found_key, stored_count    | out_valid / out_ready
//
// On an insert, every cell compares its key with the new key at once and the
// chain shifts the greater keys up by one cell in the accept cycle.
// On a select, groups of eight masked cell keys are OR-ed into registers, then
// the group registers are OR-ed into the result register in the collect state;
// in_ready stays low during the collect state.
// Reset clears the key count and control; the cells themselves are not cleared.
// Outside a select, a word is taken only when the result register is free or
// drains in that cycle, so a stalled out channel holds the in channel.
module order_statistic_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic signed [oss_pkg::KEY_W-1:0]    in_new_key,
  input  logic        [oss_pkg::RANK_W-1:0]   in_rank,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [1:0]                   out_status,
  output logic signed [oss_pkg::KEY_W-1:0]    out_found_key,
  output logic        [oss_pkg::COUNT_W-1:0]  out_stored_count
);
  import oss_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                status_r, status_nxt;
  logic [KEY_W-1:0]       found_r, found_nxt;
  logic [COUNT_W-1:0]     scount_r, scount_nxt;

  status_t                pend_status_r, pend_status_nxt;
  logic [KEY_W-1:0]       group_r [GROUPS];
  logic [KEY_W-1:0]       group_nxt [GROUPS];

  logic accept, is_insert, full, sel_ok;
  logic load_direct, load_gather, load_collect;
  logic [RANK_W-1:0]     rank_m1;
  logic [KEY_W-1:0]      gather_or;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic [CNT_W-1:0]      count_ins;

  cell_ctrl_t               ctrl     [CAPACITY];
  logic                     cell_gt  [CAPACITY];
  logic signed [KEY_W-1:0]  cell_key [CAPACITY];
  logic [KEY_W-1:0]         cell_sel [CAPACITY];

  assign accept    = in_valid && in_ready;
  assign is_insert = (in_func == FUNC_INSERT);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign rank_m1   = in_rank - RANK_W'(1);
  // rank is in range when 1 <= rank <= count
  assign sel_ok    = (in_rank != '0) && (in_rank <= RANK_W'(count_r));
  assign count_ins = count_r + CNT_W'(1);

  // Per-cell control: occupancy, tail and rank match come from the count
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctrl[i].ins  = accept && is_insert && !full;
    assign ctrl[i].occ  = (CNT_W'(i) < count_r);
    assign ctrl[i].tail = (CNT_W'(i) == count_r);
    assign ctrl[i].hit  = !is_insert && sel_ok && (rank_m1 == RANK_W'(i));

    if (i == 0) begin : g_head
      oss_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl[i]),
        .new_key  (in_new_key),
        .left_gt  (1'b0),
        .left_key (in_new_key),
        .gt       (cell_gt[i]),
        .key      (cell_key[i]),
        .sel_key  (cell_sel[i])
      );
    end else begin : g_body
      oss_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl[i]),
        .new_key  (in_new_key),
        .left_gt  (cell_gt[i-1]),
        .left_key (cell_key[i-1]),
        .gt       (cell_gt[i]),
        .key      (cell_key[i]),
        .sel_key  (cell_sel[i])
      );
    end
  end

  // First level of the gather tree: OR eight masked cell keys per group
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_nxt[g] = '0;
      for (int j = 0; j < GROUP_N; j++) begin
        if (g * GROUP_N + j < CAPACITY) begin
          group_nxt[g] = group_nxt[g] | cell_sel[g * GROUP_N + j];
        end
      end
    end
  end

  // Second level: OR the group registers
  always_comb begin
    gather_or = '0;
    for (int g = 0; g < GROUPS; g++) begin
      gather_or = gather_or | group_r[g];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_insert) begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_COLLECT: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready     = 1'b0;
    load_direct  = 1'b0;
    load_gather  = 1'b0;
    load_collect = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = !out_valid_r || out_ready;
        load_direct = accept && is_insert;
        load_gather = accept && !is_insert;
      end
      ST_COLLECT: load_collect = 1'b1;
      default: ;
    endcase
  end

  // Count and result register
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    status_nxt      = status_r;
    found_nxt       = found_r;
    scount_nxt      = scount_r;
    pend_status_nxt = pend_status_r;
    if (load_direct && !full) begin
      count_nxt = count_ins;
    end
    if (load_direct) begin
      out_valid_nxt = 1'b1;
      status_nxt    = full ? STATUS_FULL : STATUS_OK;
      found_nxt     = '0;
      scount_nxt    = count_ext[COUNT_W-1:0];
    end
    if (load_gather) begin
      pend_status_nxt = sel_ok ? STATUS_OK : STATUS_RANGE;
    end
    if (load_collect) begin
      out_valid_nxt = 1'b1;
      status_nxt    = pend_status_r;
      found_nxt     = gather_or;
      scount_nxt    = count_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    found_r       <= found_nxt;
    scount_r      <= scount_nxt;
    pend_status_r <= pend_status_nxt;
    if (load_gather) begin
      for (int g = 0; g < GROUPS; g++) begin
        group_r[g] <= group_nxt[g];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_found_key    = found_r;
  assign out_stored_count = scount_r;

endmodule

// ===== tb/order_statistic_store_test.sv =====
// Self-checking testbench for order_statistic_store: sorted insert, rank select, full store.
// Needs oss_pkg and the order_statistic_store RTL; a scoreboard class predicts every result word.
module order_statistic_store_test;
  import oss_pkg::*;

  localparam int LIMIT     = 200000;  // cycle budget, far above the slowest correct run
  localparam int DRAIN_CYC = 8;       // settle time after the last result

  // Expected result word
  typedef struct {
    status_t                  status;
    logic signed [KEY_W-1:0]  key;
    logic [COUNT_W-1:0]       count;
  } rank_result_t;

  // Keep a sorted copy of the stored keys and the queue of results still owed.
  class rank_scoreboard;
    logic signed [KEY_W-1:0] keys[$];
    rank_result_t            pending[$];
    int                      mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Predict the result of one accepted input word.
    function void note_word(func_t f, logic signed [KEY_W-1:0] k, logic [RANK_W-1:0] r);
      rank_result_t want;
      int           pos;
      want.status = STATUS_OK;
      want.key    = '0;
      if (f == FUNC_INSERT) begin
        if (keys.size() >= CAPACITY) begin
          want.status = STATUS_FULL;
        end else begin
          // Equal keys go after the ones already held.
          pos = 0;
          while (pos < keys.size() && keys[pos] <= k) pos++;
          keys.insert(pos, k);
        end
      end else if (r == 0 || r > keys.size()) begin
        want.status = STATUS_RANGE;
      end else begin
        want.key = keys[r - 1];
      end
      want.count = COUNT_W'(keys.size());
      pending.push_back(want);
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_result(logic [1:0] st, logic signed [KEY_W-1:0] k,
                               logic [COUNT_W-1:0] c);
      rank_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d key %0d count %0d", st, k, c);
        return;
      end
      want = pending.pop_front();
      if (st !== want.status || k !== want.key || c !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected status %0d key %0d count %0d, got %0d %0d %0d",
                   want.status, want.key, want.count, st, k, c);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_func;
  logic signed [KEY_W-1:0]    in_new_key;
  logic        [RANK_W-1:0]   in_rank;
  logic                       out_valid;
  logic                       out_ready;
  logic        [1:0]          out_status;
  logic signed [KEY_W-1:0]    out_found_key;
  logic        [COUNT_W-1:0]  out_stored_count;

  rank_scoreboard sb;
  int             cycles = 0;
  int             sender_idle;     // percent of cycles the sender holds off
  int             receiver_stall;  // percent of cycles the receiver holds off
  int             held = 0;        // keys the driver knows are stored

  order_statistic_store dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_new_key       (in_new_key),
    .in_rank          (in_rank),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_key    (out_found_key),
    .out_stored_count (out_stored_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Stall the result channel at the rate of the current phase.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= receiver_stall);

  // Watch both channels at the edge. Check the result first: a result word seen at
  // this edge can never belong to the input word taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_status, out_found_key, out_stored_count);
      if (in_valid && in_ready) sb.note_word(func_t'(in_func), in_new_key, in_rank);
    end
  end

  // Give up once the cycle budget is spent.
  initial begin : watchdog
    while (cycles < LIMIT) @(posedge clk);
    $display("order_statistic_store_test: done, errors");
    $finish;
  end

  // Drive one input word: idle at random first, then hold valid and payload until taken.
  task automatic send_word(input func_t f, input logic signed [KEY_W-1:0] k,
                           input logic [RANK_W-1:0] r);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_new_key <= k;
    in_rank    <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (f == FUNC_INSERT && held < CAPACITY) held++;
  endtask

  // Mix extremes, a narrow band that forces duplicates, and full-width keys.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(15);
    case (sel)
      0: pick_key = 32'sh8000_0000;
      1: pick_key = 32'sh7fff_ffff;
      2: pick_key = '0;
      3: pick_key = -32'sd1;
      4, 5, 6, 7: pick_key = $signed($urandom_range(16)) - 8;
      default: pick_key = $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int                       n;
    int                       sel;
    func_t                    f;
    logic signed [KEY_W-1:0]  k;
    logic [RANK_W-1:0]        r;

    sb = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_INSERT;
    in_new_key     <= '0;
    in_rank        <= '0;
    sender_idle    = 32;
    receiver_stall = 49;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Select from an empty store: every rank is out of range.
    send_word(FUNC_SELECT, $urandom, 16'd0);
    send_word(FUNC_SELECT, $urandom, 16'd1);
    send_word(FUNC_SELECT, $urandom, 16'hffff);
    // Fill with extremes and a duplicate zero.
    send_word(FUNC_INSERT, 32'sd0, RANK_W'($urandom));
    send_word(FUNC_INSERT, 32'sh8000_0000, RANK_W'($urandom));
    send_word(FUNC_INSERT, 32'sh7fff_ffff, RANK_W'($urandom));
    send_word(FUNC_INSERT, -32'sd1, RANK_W'($urandom));
    send_word(FUNC_INSERT, 32'sd0, RANK_W'($urandom));
    send_word(FUNC_INSERT, 32'sd1, RANK_W'($urandom));
    // Select the ends, the middle duplicates, rank zero and just past the count.
    send_word(FUNC_SELECT, $urandom, 16'd1);
    send_word(FUNC_SELECT, $urandom, 16'd6);
    send_word(FUNC_SELECT, $urandom, 16'd7);
    send_word(FUNC_SELECT, $urandom, 16'd0);
    send_word(FUNC_SELECT, $urandom, 16'd3);
    send_word(FUNC_SELECT, $urandom, 16'd4);
    // Duplicate the extremes, then select both ends and a rank far out of range.
    send_word(FUNC_INSERT, 32'sh7fff_ffff, RANK_W'($urandom));
    send_word(FUNC_INSERT, 32'sh8000_0000, RANK_W'($urandom));
    send_word(FUNC_SELECT, $urandom, 16'd1);
    send_word(FUNC_SELECT, $urandom, 16'd2);
    send_word(FUNC_SELECT, $urandom, 16'd8);
    send_word(FUNC_SELECT, $urandom, 16'h8000);

    // Random part: mostly selects on held ranks, inserts fill the store by midway.
    for (n = 0; n < 525; n++) begin
      if (n == 175) begin
        sender_idle    = 49;
        receiver_stall = 32;
      end else if (n == 350) begin
        sender_idle    = 0;
        receiver_stall = 0;
      end
      f = ($urandom_range(3) == 0) ? FUNC_INSERT : FUNC_SELECT;
      k = pick_key();
      sel = $urandom_range(9);
      if (sel < 7 && held > 0)
        r = RANK_W'($urandom_range(held, 1));
      else if (sel == 7)
        r = ($urandom_range(1) != 0) ? RANK_W'(held + 1) : '0;
      else if (sel == 8)
        r = RANK_W'($urandom_range(16'hffff));
      else
        r = RANK_W'($urandom_range(CAPACITY + 2));
      send_word(f, k, r);
    end

    // Make sure the full store is reached, then push against it.
    while (held < CAPACITY) send_word(FUNC_INSERT, pick_key(), RANK_W'($urandom));
    send_word(FUNC_INSERT, pick_key(), RANK_W'($urandom));
    send_word(FUNC_INSERT, 32'sh8000_0000, RANK_W'($urandom));
    send_word(FUNC_SELECT, $urandom, RANK_W'(CAPACITY));
    send_word(FUNC_SELECT, $urandom, RANK_W'(CAPACITY + 1));
    send_word(FUNC_SELECT, $urandom, 16'd1);
    in_valid <= 1'b0;

    // Drain: let the last prediction land, wait for every result, then settle.
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    sb.mismatches += sb.pending.size();
    if (sb.mismatches == 0)
      $display("order_statistic_store_test: done, clean");
    else
      $display("order_statistic_store_test: done, errors");
    $finish;
  end

endmodule
